// ===== design/assert_macros.svh =====
// assertion macros shared by the clustering rtl
// a use expands to one concurrent assertion, or to nothing when NO_ASSERTIONS is set
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define ASSERT_IMPLIES(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error("assertion failed");
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define ASSERT_IMPLIES(lbl, clk, rstn, ante, cons)
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif
`endif

// ===== design/kmc_pkg.sv =====
// shared types and constants for the k-means clustering block
// no dependencies
`default_nettype none
package kmc_pkg;
  localparam int MAX_POINTS_DEF   = 1024;
  localparam int MAX_DIMS_DEF     = 8;
  localparam int MAX_CLUSTERS_DEF = 16;
  localparam int SAMPLE_BITS_DEF  = 16;

  localparam int CMD_W      = 3;
  localparam int KIND_W     = 2;
  localparam int LABEL_W    = 4;
  localparam int PIDX_W     = 10;
  localparam int CIDX_W     = 4;
  localparam int DIDX_W     = 3;
  localparam int ITER_W     = 11;
  localparam int INERTIA_W  = 46;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;
  localparam int NPTS_W     = 11;
  localparam int NDIM_W     = 4;
  localparam int NCLU_W     = 5;
  localparam int TOL_W      = 32;

  localparam logic [CMD_W-1:0] CMD_LOAD_POINT = 3'd0;
  localparam logic [CMD_W-1:0] CMD_LOAD_CENT  = 3'd1;
  localparam logic [CMD_W-1:0] CMD_RUN        = 3'd2;
  localparam logic [CMD_W-1:0] CMD_READ_LABEL = 3'd3;
  localparam logic [CMD_W-1:0] CMD_READ_CENT  = 3'd4;

  localparam logic [KIND_W-1:0] KIND_RUN   = 2'd0;
  localparam logic [KIND_W-1:0] KIND_LABEL = 2'd1;
  localparam logic [KIND_W-1:0] KIND_CENT  = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_NUM_POINTS = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_NUM_DIMS   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_NUM_CLUST  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_ITER   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_TOL_SQ     = 3'd4;

  localparam logic [NPTS_W-1:0] RST_NUM_POINTS = 11'd1024;
  localparam logic [NDIM_W-1:0] RST_NUM_DIMS   = 4'd2;
  localparam logic [NCLU_W-1:0] RST_NUM_CLUST  = 5'd4;
  localparam logic [ITER_W-1:0] RST_MAX_ITER   = 11'd100;
  localparam logic [TOL_W-1:0]  RST_TOL_SQ     = 32'd0;

  localparam logic [INERTIA_W-1:0] INERTIA_MAX = '1;
endpackage
`default_nettype wire

// ===== design/kmc_ram.sv =====
// generic single-write, single-read ram with registered read data
// no dependencies
`default_nettype none
module kmc_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// ===== design/kmeans_lloyd_clustering_top.sv =====
// Lloyd k-means clustering engine: control sequencer around five kmc_ram memories
// depends on kmc_pkg, kmc_ram and assert_macros.svh
//
//  channel | ports                              | beat moves
//  in      | in_valid / in_stall               | command, indexes, sample
//  out     | out_valid / out_stall             | kind, label, centroid, iterations, inertia
//  cfg     | cfg_we, cfg_index, cfg_wdata      | one register write, no wait
//
// loads write the ram when accepted; a read holds in_stall through S_RD and its result beat is
//   registered out of S_RD
// a run repeats iterations of a sweep, an assignment pass and a centroid update paced by
//   the shared squarer and the one-bit-per-cycle divider, then ends with a final
//   assignment pass
// after reset a clearing pass over all MAX_POINTS labels zeroes them; in_stall is high
// in_stall is also high while a run or read is busy or a result waits stalled
`default_nettype none
`include "assert_macros.svh"
module kmeans_lloyd_clustering_top #(
  parameter int MAX_POINTS   = kmc_pkg::MAX_POINTS_DEF,
  parameter int MAX_DIMS     = kmc_pkg::MAX_DIMS_DEF,
  parameter int MAX_CLUSTERS = kmc_pkg::MAX_CLUSTERS_DEF,
  parameter int SAMPLE_BITS  = kmc_pkg::SAMPLE_BITS_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              cfg_we,
  input  wire logic [kmc_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [kmc_pkg::CFG_DATA_W-1:0]    cfg_wdata,
  input  wire logic                              in_valid,
  output logic                                   in_stall,
  input  wire logic [kmc_pkg::CMD_W-1:0]         in_command,
  input  wire logic [kmc_pkg::PIDX_W-1:0]        in_point_index,
  input  wire logic [kmc_pkg::CIDX_W-1:0]        in_cluster_index,
  input  wire logic [kmc_pkg::DIDX_W-1:0]        in_dim_index,
  input  wire logic signed [SAMPLE_BITS-1:0]     in_sample_value,
  output logic                                   out_valid,
  input  wire logic                              out_stall,
  output logic [kmc_pkg::KIND_W-1:0]             out_result_kind,
  output logic [kmc_pkg::LABEL_W-1:0]            out_label,
  output logic signed [SAMPLE_BITS-1:0]          out_centroid_value,
  output logic [kmc_pkg::ITER_W-1:0]             out_iterations_done,
  output logic [kmc_pkg::INERTIA_W-1:0]          out_inertia
);
  import kmc_pkg::*;

  localparam int SB      = SAMPLE_BITS;
  localparam int PAW     = $clog2(MAX_POINTS);
  localparam int CAW     = $clog2(MAX_CLUSTERS);
  localparam int DAW     = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;
  localparam int PDEPTH  = MAX_POINTS * MAX_DIMS;
  localparam int CDEPTH  = MAX_CLUSTERS * MAX_DIMS;
  localparam int PMW     = $clog2(PDEPTH);
  localparam int CMW     = $clog2(CDEPTH);
  localparam int CNTW    = $clog2(MAX_POINTS + 1);
  localparam int KW      = $clog2(MAX_CLUSTERS + 1);
  localparam int DCW     = $clog2(MAX_DIMS + 1);
  localparam int SUMW    = SB + PAW + 1;
  localparam int NUMW    = SB + PAW;
  localparam int SQW     = 2 * SB + 1;
  localparam int DW      = SQW + $clog2(MAX_DIMS + 1);
  localparam int CW      = (DW > TOL_W) ? DW : TOL_W;
  localparam int TW      = ((DW > INERTIA_W) ? DW : INERTIA_W) + 1;
  localparam int DIVCW   = $clog2(NUMW);

  typedef enum logic [18:0] {
    S_CLR_LBL = 19'h00001,
    S_IDLE    = 19'h00002,
    S_RD      = 19'h00004,
    S_SWEEP   = 19'h00008,
    S_A_RD    = 19'h00010,
    S_A_SQ    = 19'h00020,
    S_A_ADD   = 19'h00040,
    S_A_CMP   = 19'h00080,
    S_A_LBL   = 19'h00100,
    S_ACC_RD  = 19'h00200,
    S_ACC_WR  = 19'h00400,
    S_U_CNT   = 19'h00800,
    S_U_CHK   = 19'h01000,
    S_U_RD    = 19'h02000,
    S_U_LD    = 19'h04000,
    S_U_DIV   = 19'h08000,
    S_U_SQ    = 19'h10000,
    S_U_ADD   = 19'h20000,
    S_U_END   = 19'h40000
  } state_t;

  function automatic logic [PMW-1:0] paddr(input logic [PAW-1:0] pi, input logic [DAW-1:0] dj);
    paddr = PMW'(pi) * PMW'(MAX_DIMS) + PMW'(dj);
  endfunction

  function automatic logic [CMW-1:0] caddr(input logic [CAW-1:0] ci, input logic [DAW-1:0] dj);
    caddr = CMW'(ci) * CMW'(MAX_DIMS) + CMW'(dj);
  endfunction

  // configuration
  logic [NPTS_W-1:0] num_points_r;
  logic [NDIM_W-1:0] num_dims_r;
  logic [NCLU_W-1:0] num_clust_r;
  logic [ITER_W-1:0] max_iter_r;
  logic [TOL_W-1:0]  tol_r;

  // control
  state_t state_r, state_nxt;
  logic [PAW-1:0]   lc_r, lc_nxt;
  logic [CNTW-1:0]  n_r, n_nxt;
  logic [DCW-1:0]   d_r, d_nxt;
  logic [KW-1:0]    k_r, k_nxt;
  logic [ITER_W-1:0] lim_r, lim_nxt;
  logic [ITER_W-1:0] it_r, it_nxt;
  logic             final_r, final_nxt;
  logic [PAW-1:0]   i_r, i_nxt;
  logic [CAW-1:0]   c_r, c_nxt;
  logic [DAW-1:0]   j_r, j_nxt;
  logic [CAW-1:0]   bc_r, bc_nxt;
  logic [DIVCW-1:0] dcnt_r, dcnt_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic [KIND_W-1:0] rd_kind_r, rd_kind_nxt;
  logic             rd_ok_r, rd_ok_nxt;

  // datapath
  logic [SQW-1:0]   sq_r, sq_nxt;
  logic [DW-1:0]    dist_r, dist_nxt;
  logic [DW-1:0]    best_r, best_nxt;
  logic [DW-1:0]    moved_r, moved_nxt;
  logic [DW-1:0]    shift_r, shift_nxt;
  logic [INERTIA_W-1:0] total_r, total_nxt;
  logic [CNTW-1:0]  cnt_r, cnt_nxt;
  logic [NUMW-1:0]  num_r, num_nxt;
  logic [NUMW-1:0]  quo_r, quo_nxt;
  logic [CNTW-1:0]  rem_r, rem_nxt;
  logic             neg_r, neg_nxt;
  logic [SB-1:0]    old_cent_r, old_cent_nxt;

  logic [KIND_W-1:0]    out_kind_r, out_kind_nxt;
  logic [LABEL_W-1:0]   out_label_r, out_label_nxt;
  logic [SB-1:0]        out_cent_r, out_cent_nxt;
  logic [ITER_W-1:0]    out_iter_r, out_iter_nxt;
  logic [INERTIA_W-1:0] out_inertia_r, out_inertia_nxt;
  logic                 out_load;

  // memory ports
  logic            p_we;
  logic [PMW-1:0]  p_waddr, p_raddr;
  logic [SB-1:0]   p_wdata, p_rdata;
  logic            c_we;
  logic [CMW-1:0]  c_waddr, c_raddr;
  logic [SB-1:0]   c_wdata, c_rdata;
  logic            s_we;
  logic [CMW-1:0]  s_waddr, s_raddr;
  logic [SUMW-1:0] s_wdata, s_rdata;
  logic            n_we;
  logic [CAW-1:0]  n_waddr, n_raddr;
  logic [CNTW-1:0] n_wdata, n_rdata;
  logic            l_we;
  logic [PAW-1:0]  l_waddr, l_raddr;
  logic [CAW-1:0]  l_wdata, l_rdata;

  // shared squarer
  logic [SB-1:0]          sq_a, sq_b;
  logic signed [SB:0]     diff_c;
  logic signed [2*SB+1:0] prod_c;

  logic            in_acc;
  logic            p_ok, c_ok, l_ok;
  logic            last_j, last_c, last_i;
  logic [CNTW-1:0] n_clamp;
  logic [DCW-1:0]  d_clamp;
  logic [KW-1:0]   k_clamp;
  logic [SUMW-1:0] s_mag;
  logic [CNTW:0]   rem_sh;
  logic [SB-1:0]   nv_c;
  logic [TW-1:0]   tsum;
  logic [ITER_W-1:0] it_inc;

  kmc_ram #(.WIDTH(SB), .DEPTH(PDEPTH)) u_point_ram (
    .clk(clk), .we(p_we), .waddr(p_waddr), .wdata(p_wdata), .raddr(p_raddr), .rdata(p_rdata)
  );
  kmc_ram #(.WIDTH(SB), .DEPTH(CDEPTH)) u_cent_ram (
    .clk(clk), .we(c_we), .waddr(c_waddr), .wdata(c_wdata), .raddr(c_raddr), .rdata(c_rdata)
  );
  kmc_ram #(.WIDTH(SUMW), .DEPTH(CDEPTH)) u_sum_ram (
    .clk(clk), .we(s_we), .waddr(s_waddr), .wdata(s_wdata), .raddr(s_raddr), .rdata(s_rdata)
  );
  kmc_ram #(.WIDTH(CNTW), .DEPTH(MAX_CLUSTERS)) u_count_ram (
    .clk(clk), .we(n_we), .waddr(n_waddr), .wdata(n_wdata), .raddr(n_raddr), .rdata(n_rdata)
  );
  kmc_ram #(.WIDTH(CAW), .DEPTH(MAX_POINTS)) u_label_ram (
    .clk(clk), .we(l_we), .waddr(l_waddr), .wdata(l_wdata), .raddr(l_raddr), .rdata(l_rdata)
  );

  assign in_stall = (state_r != S_IDLE) || (out_valid_r && out_stall);
  assign in_acc   = in_valid && !in_stall;

  assign out_valid           = out_valid_r;
  assign out_result_kind     = out_kind_r;
  assign out_label           = out_label_r;
  assign out_centroid_value  = out_cent_r;
  assign out_iterations_done = out_iter_r;
  assign out_inertia         = out_inertia_r;

  assign diff_c = (SB+1)'($signed(sq_a)) - (SB+1)'($signed(sq_b));
  assign prod_c = diff_c * diff_c;

  always_comb begin
    p_ok = (32'(in_point_index) < 32'(MAX_POINTS)) && (32'(in_dim_index) < 32'(MAX_DIMS));
    c_ok = (32'(in_cluster_index) < 32'(MAX_CLUSTERS)) && (32'(in_dim_index) < 32'(MAX_DIMS));
    l_ok = 32'(in_point_index) < 32'(MAX_POINTS);

    // out-of-range register values clamp into the supported range
    if (num_points_r == '0) begin
      n_clamp = CNTW'(1);
    end else if (32'(num_points_r) > 32'(MAX_POINTS)) begin
      n_clamp = CNTW'(MAX_POINTS);
    end else begin
      n_clamp = CNTW'(num_points_r);
    end
    if (num_dims_r == '0) begin
      d_clamp = DCW'(1);
    end else if (32'(num_dims_r) > 32'(MAX_DIMS)) begin
      d_clamp = DCW'(MAX_DIMS);
    end else begin
      d_clamp = DCW'(num_dims_r);
    end
    if (num_clust_r == '0) begin
      k_clamp = KW'(1);
    end else if (32'(num_clust_r) > 32'(MAX_CLUSTERS)) begin
      k_clamp = KW'(MAX_CLUSTERS);
    end else begin
      k_clamp = KW'(num_clust_r);
    end

    last_j = DCW'(j_r) == d_r - DCW'(1);
    last_c = KW'(c_r) == k_r - KW'(1);
    last_i = CNTW'(i_r) == n_r - CNTW'(1);

    s_mag  = s_rdata[SUMW-1] ? (SUMW'(0) - s_rdata) : s_rdata;
    rem_sh = {rem_r, num_r[NUMW-1]};
    nv_c   = neg_r ? (SB'(0) - quo_r[SB-1:0]) : quo_r[SB-1:0];
    tsum   = TW'(total_r) + TW'(best_r);
    it_inc = it_r + ITER_W'(1);

    sq_a = p_rdata;
    sq_b = c_rdata;
    if (state_r == S_U_SQ) begin
      sq_a = nv_c;
      sq_b = old_cent_r;
    end

    state_nxt    = state_r;
    lc_nxt       = lc_r;
    n_nxt        = n_r;
    d_nxt        = d_r;
    k_nxt        = k_r;
    lim_nxt      = lim_r;
    it_nxt       = it_r;
    final_nxt    = final_r;
    i_nxt        = i_r;
    c_nxt        = c_r;
    j_nxt        = j_r;
    bc_nxt       = bc_r;
    dcnt_nxt     = dcnt_r;
    rd_kind_nxt  = rd_kind_r;
    rd_ok_nxt    = rd_ok_r;
    sq_nxt       = sq_r;
    dist_nxt     = dist_r;
    best_nxt     = best_r;
    moved_nxt    = moved_r;
    shift_nxt    = shift_r;
    total_nxt    = total_r;
    cnt_nxt      = cnt_r;
    num_nxt      = num_r;
    quo_nxt      = quo_r;
    rem_nxt      = rem_r;
    neg_nxt      = neg_r;
    old_cent_nxt = old_cent_r;

    out_load        = 1'b0;
    out_kind_nxt    = out_kind_r;
    out_label_nxt   = out_label_r;
    out_cent_nxt    = out_cent_r;
    out_iter_nxt    = out_iter_r;
    out_inertia_nxt = out_inertia_r;

    p_we    = 1'b0;
    p_waddr = paddr(PAW'(in_point_index), DAW'(in_dim_index));
    p_wdata = in_sample_value;
    p_raddr = paddr(i_r, j_r);
    c_we    = 1'b0;
    c_waddr = caddr(CAW'(in_cluster_index), DAW'(in_dim_index));
    c_wdata = in_sample_value;
    c_raddr = caddr(c_r, j_r);
    s_we    = 1'b0;
    s_waddr = caddr(c_r, j_r);
    s_wdata = '0;
    s_raddr = caddr(c_r, j_r);
    n_we    = 1'b0;
    n_waddr = c_r;
    n_wdata = '0;
    n_raddr = c_r;
    l_we    = 1'b0;
    l_waddr = i_r;
    l_wdata = bc_r;
    l_raddr = PAW'(in_point_index);

    case (state_r)
      S_CLR_LBL: begin
        l_we    = 1'b1;
        l_waddr = lc_r;
        l_wdata = '0;
        if (lc_r == PAW'(MAX_POINTS - 1)) begin
          state_nxt = S_IDLE;
        end else begin
          lc_nxt = lc_r + PAW'(1);
        end
      end
      S_IDLE: begin
        c_raddr = caddr(CAW'(in_cluster_index), DAW'(in_dim_index));
        if (in_acc) begin
          case (in_command)
            CMD_LOAD_POINT: p_we = p_ok;
            CMD_LOAD_CENT:  c_we = c_ok;
            CMD_RUN: begin
              n_nxt     = n_clamp;
              d_nxt     = d_clamp;
              k_nxt     = k_clamp;
              lim_nxt   = (max_iter_r == '0) ? ITER_W'(1) : max_iter_r;
              it_nxt    = '0;
              final_nxt = 1'b0;
              c_nxt     = '0;
              j_nxt     = '0;
              state_nxt = S_SWEEP;
            end
            CMD_READ_LABEL: begin
              rd_kind_nxt = KIND_LABEL;
              rd_ok_nxt   = l_ok;
              state_nxt   = S_RD;
            end
            CMD_READ_CENT: begin
              rd_kind_nxt = KIND_CENT;
              rd_ok_nxt   = c_ok;
              state_nxt   = S_RD;
            end
            default: ;
          endcase
        end
      end
      S_RD: begin
        out_load        = 1'b1;
        out_kind_nxt    = rd_kind_r;
        out_label_nxt   = '0;
        out_cent_nxt    = '0;
        out_iter_nxt    = '0;
        out_inertia_nxt = '0;
        if (rd_ok_r && rd_kind_r == KIND_LABEL) begin
          out_label_nxt = LABEL_W'(l_rdata);
        end
        if (rd_ok_r && rd_kind_r == KIND_CENT) begin
          out_cent_nxt = c_rdata;
        end
        state_nxt = S_IDLE;
      end
      // zero the sums and counts of the clusters in use
      S_SWEEP: begin
        s_we = 1'b1;
        n_we = 1'b1;
        if (last_j) begin
          j_nxt = '0;
          if (last_c) begin
            c_nxt     = '0;
            i_nxt     = '0;
            dist_nxt  = '0;
            state_nxt = S_A_RD;
          end else begin
            c_nxt = c_r + CAW'(1);
          end
        end else begin
          j_nxt = j_r + DAW'(1);
        end
      end
      S_A_RD: state_nxt = S_A_SQ;
      S_A_SQ: begin
        sq_nxt    = prod_c[SQW-1:0];
        state_nxt = S_A_ADD;
      end
      S_A_ADD: begin
        dist_nxt = dist_r + DW'(sq_r);
        if (last_j) begin
          state_nxt = S_A_CMP;
        end else begin
          j_nxt     = j_r + DAW'(1);
          state_nxt = S_A_RD;
        end
      end
      // strict compare keeps the lowest index on ties
      S_A_CMP: begin
        if (c_r == '0 || dist_r < best_r) begin
          best_nxt = dist_r;
          bc_nxt   = c_r;
        end
        j_nxt    = '0;
        dist_nxt = '0;
        if (last_c) begin
          state_nxt = S_A_LBL;
        end else begin
          c_nxt     = c_r + CAW'(1);
          state_nxt = S_A_RD;
        end
      end
      S_A_LBL: begin
        l_we      = 1'b1;
        total_nxt = (tsum > TW'(INERTIA_MAX)) ? INERTIA_MAX : tsum[INERTIA_W-1:0];
        c_nxt     = '0;
        j_nxt     = '0;
        if (!final_r) begin
          state_nxt = S_ACC_RD;
        end else if (last_i) begin
          out_load        = 1'b1;
          out_kind_nxt    = KIND_RUN;
          out_label_nxt   = '0;
          out_cent_nxt    = '0;
          out_iter_nxt    = it_r;
          out_inertia_nxt = total_nxt;
          state_nxt       = S_IDLE;
        end else begin
          i_nxt     = i_r + PAW'(1);
          state_nxt = S_A_RD;
        end
      end
      S_ACC_RD: begin
        s_raddr   = caddr(bc_r, j_r);
        n_raddr   = bc_r;
        state_nxt = S_ACC_WR;
      end
      // write-back in the state after the read, so the next read sees it
      S_ACC_WR: begin
        s_we    = 1'b1;
        s_waddr = caddr(bc_r, j_r);
        s_wdata = s_rdata + SUMW'($signed(p_rdata));
        n_we    = (j_r == '0);
        n_waddr = bc_r;
        n_wdata = n_rdata + CNTW'(1);
        if (last_j) begin
          j_nxt = '0;
          c_nxt = '0;
          if (last_i) begin
            shift_nxt = '0;
            state_nxt = S_U_CNT;
          end else begin
            i_nxt     = i_r + PAW'(1);
            dist_nxt  = '0;
            state_nxt = S_A_RD;
          end
        end else begin
          j_nxt     = j_r + DAW'(1);
          state_nxt = S_ACC_RD;
        end
      end
      S_U_CNT: state_nxt = S_U_CHK;
      S_U_CHK: begin
        cnt_nxt   = n_rdata;
        j_nxt     = '0;
        moved_nxt = '0;
        if (n_rdata != '0) begin
          state_nxt = S_U_RD;
        end else if (last_c) begin
          state_nxt = S_U_END;
        end else begin
          c_nxt     = c_r + CAW'(1);
          state_nxt = S_U_CNT;
        end
      end
      S_U_RD: state_nxt = S_U_LD;
      S_U_LD: begin
        old_cent_nxt = c_rdata;
        neg_nxt      = s_rdata[SUMW-1];
        num_nxt      = NUMW'(s_mag) + NUMW'(cnt_r >> 1);
        rem_nxt      = '0;
        quo_nxt      = '0;
        dcnt_nxt     = '0;
        state_nxt    = S_U_DIV;
      end
      // restoring division, one quotient bit per cycle
      S_U_DIV: begin
        if (rem_sh >= {1'b0, cnt_r}) begin
          rem_nxt = CNTW'(rem_sh - {1'b0, cnt_r});
          quo_nxt = {quo_r[NUMW-2:0], 1'b1};
        end else begin
          rem_nxt = rem_sh[CNTW-1:0];
          quo_nxt = {quo_r[NUMW-2:0], 1'b0};
        end
        num_nxt  = {num_r[NUMW-2:0], 1'b0};
        dcnt_nxt = dcnt_r + DIVCW'(1);
        if (dcnt_r == DIVCW'(NUMW - 1)) begin
          state_nxt = S_U_SQ;
        end
      end
      S_U_SQ: begin
        c_we      = 1'b1;
        c_waddr   = caddr(c_r, j_r);
        c_wdata   = nv_c;
        sq_nxt    = prod_c[SQW-1:0];
        state_nxt = S_U_ADD;
      end
      S_U_ADD: begin
        moved_nxt = moved_r + DW'(sq_r);
        if (last_j) begin
          if (moved_nxt > shift_r) begin
            shift_nxt = moved_nxt;
          end
          j_nxt = '0;
          if (last_c) begin
            state_nxt = S_U_END;
          end else begin
            c_nxt     = c_r + CAW'(1);
            state_nxt = S_U_CNT;
          end
        end else begin
          j_nxt     = j_r + DAW'(1);
          state_nxt = S_U_RD;
        end
      end
      S_U_END: begin
        it_nxt = it_inc;
        c_nxt  = '0;
        j_nxt  = '0;
        if ((CW'(shift_r) <= CW'(tol_r)) || (it_inc >= lim_r)) begin
          final_nxt = 1'b1;
          total_nxt = '0;
          i_nxt     = '0;
          dist_nxt  = '0;
          state_nxt = S_A_RD;
        end else begin
          state_nxt = S_SWEEP;
        end
      end
      default: state_nxt = S_IDLE;
    endcase

    out_valid_nxt = out_load || (out_valid_r && out_stall);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_CLR_LBL;
      lc_r         <= '0;
      out_valid_r  <= 1'b0;
      final_r      <= 1'b0;
      num_points_r <= RST_NUM_POINTS;
      num_dims_r   <= RST_NUM_DIMS;
      num_clust_r  <= RST_NUM_CLUST;
      max_iter_r   <= RST_MAX_ITER;
      tol_r        <= RST_TOL_SQ;
    end else begin
      state_r     <= state_nxt;
      lc_r        <= lc_nxt;
      out_valid_r <= out_valid_nxt;
      final_r     <= final_nxt;
      if (cfg_we) begin
        case (cfg_index)
          CFG_NUM_POINTS: num_points_r <= cfg_wdata[NPTS_W-1:0];
          CFG_NUM_DIMS:   num_dims_r   <= cfg_wdata[NDIM_W-1:0];
          CFG_NUM_CLUST:  num_clust_r  <= cfg_wdata[NCLU_W-1:0];
          CFG_MAX_ITER:   max_iter_r   <= cfg_wdata[ITER_W-1:0];
          CFG_TOL_SQ:     tol_r        <= cfg_wdata[TOL_W-1:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    n_r           <= n_nxt;
    d_r           <= d_nxt;
    k_r           <= k_nxt;
    lim_r         <= lim_nxt;
    it_r          <= it_nxt;
    i_r           <= i_nxt;
    c_r           <= c_nxt;
    j_r           <= j_nxt;
    bc_r          <= bc_nxt;
    dcnt_r        <= dcnt_nxt;
    rd_kind_r     <= rd_kind_nxt;
    rd_ok_r       <= rd_ok_nxt;
    sq_r          <= sq_nxt;
    dist_r        <= dist_nxt;
    best_r        <= best_nxt;
    moved_r       <= moved_nxt;
    shift_r       <= shift_nxt;
    total_r       <= total_nxt;
    cnt_r         <= cnt_nxt;
    num_r         <= num_nxt;
    quo_r         <= quo_nxt;
    rem_r         <= rem_nxt;
    neg_r         <= neg_nxt;
    old_cent_r    <= old_cent_nxt;
    out_kind_r    <= out_kind_nxt;
    out_label_r   <= out_label_nxt;
    out_cent_r    <= out_cent_nxt;
    out_iter_r    <= out_iter_nxt;
    out_inertia_r <= out_inertia_nxt;
  end

  `ASSERT_IMPLIES(a_acc_cluster, clk, rst_n, state_r == S_ACC_WR, KW'(bc_r) < k_r)
  `ASSERT_IMPLIES(a_iter_bound, clk, rst_n, state_r == S_U_END, it_r < lim_r)
  `ASSERT_IMPLIES(a_div_nonzero, clk, rst_n, state_r == S_U_DIV, cnt_r != '0)
  `ASSERT_IMPLIES(a_result_slot, clk, rst_n, out_load, !out_valid_r || !out_stall)
  `ASSERT_NEXT(a_run_start, clk, rst_n, in_acc && in_command == CMD_RUN, state_r == S_SWEEP)
endmodule
`default_nettype wire
